/* hdl/rqdd_pkg.sv */
// ----------------------------------------------------------------------------
// rqdd_pkg
// Shared types, constants and tables for the RED queue drop decider.
// ----------------------------------------------------------------------------
`default_nettype none
package rqdd_pkg;

    localparam int QUEUE_LENGTH_BITS     = 16;
    localparam int AVERAGE_FRACTION_BITS = 16;
    localparam int QFIX_W                = QUEUE_LENGTH_BITS + AVERAGE_FRACTION_BITS;

    localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
    localparam logic [47:0] M_MAX         = 48'hFFFF_FFFF_FFFF;

    localparam logic [15:0] WEIGHT_RESET    = 16'd131;
    localparam logic [31:0] THRESHOLD_RESET = 32'd983040;
    localparam logic [15:0] RATE_RESET      = 16'd150;

    localparam logic [17:0] EXP2_C5 = 18'd87;

    typedef enum logic [1:0] {
        CFG_WEIGHT        = 2'd0,
        CFG_MAX_THRESHOLD = 2'd1,
        CFG_IDLE_RATE     = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MARK,
        OP_BUSY_M1,
        OP_BUSY_M2,
        OP_BUSY_SUM,
        OP_ELAPSED,
        OP_DIV_STEP,
        OP_SECS,
        OP_QR,
        OP_REM_LOAD,
        OP_M_SUM,
        OP_LOG_INIT,
        OP_LOG_SQ,
        OP_LOG_NORM,
        OP_L_FIN,
        OP_E1,
        OP_E2,
        OP_E3,
        OP_AVG_ZERO,
        OP_AVG_SHIFT,
        OP_H_INIT,
        OP_H_MUL,
        OP_H_ADD,
        OP_F_MUL,
        OP_F_FIN,
        OP_RESULT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_B1,
        S_B2,
        S_B3,
        S_ELAP,
        S_DIV1,
        S_SECS,
        S_QR,
        S_REML,
        S_DIV2,
        S_MSUM,
        S_LINIT,
        S_LSQ,
        S_LNORM,
        S_LFIN,
        S_E1,
        S_E2,
        S_E3,
        S_EDEC,
        S_HMUL,
        S_HADD,
        S_FMUL,
        S_FFIN,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic qlen_zero;
        logic e_zero;
        logic e_big;
        logic f_zero;
        logic out_full;
    } sts_t;

    // Horner coefficients, last step first
    function automatic logic [16:0] hcoef(input logic [2:0] idx);
        logic [16:0] c;
        case (idx)
            3'd0:    c = 17'd65536;
            3'd1:    c = 17'd45438;
            3'd2:    c = 17'd15743;
            3'd3:    c = 17'd3638;
            3'd4:    c = 17'd630;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/rqdd_in_if.sv */
// ----------------------------------------------------------------------------
// rqdd_in_if
// Input channel: drop check or idle mark transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface rqdd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] queue_length;
    logic [62:0] current_time_ns;

    modport source (output valid, output action, output queue_length,
                    output current_time_ns, input ready);
    modport sink   (input valid, input action, input queue_length,
                    input current_time_ns, output ready);
endinterface
`default_nettype wire

/* hdl/rqdd_out_if.sv */
// ----------------------------------------------------------------------------
// rqdd_out_if
// Output channel: drop decision and updated average.
// ----------------------------------------------------------------------------
`default_nettype none
interface rqdd_out_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic [31:0] average_length;

    modport source (output valid, output drop, output average_length, input ready);
    modport sink   (input valid, input drop, input average_length, output ready);
endinterface
`default_nettype wire

/* hdl/rqdd_datapath.sv */
// ----------------------------------------------------------------------------
// rqdd_datapath
// Average, idle stamp, config, shared multiplier, radix-16 divider by 1e9,
// log2/exp2 steps and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rqdd_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rqdd_pkg::cmd_t  cmd,
    output rqdd_pkg::sts_t       sts,
    input  wire logic            action,
    input  wire logic [15:0]     queue_length,
    input  wire logic [62:0]     current_time_ns,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 drop,
    output logic [31:0]          average_length
);

    logic [15:0] weight_reg;
    logic [31:0] thr_reg;
    logic [15:0] rate_reg;
    logic [31:0] avg_reg;
    logic [62:0] idle_reg;

    logic                                   act_reg;
    logic [rqdd_pkg::QUEUE_LENGTH_BITS-1:0] qlen_reg;
    logic [62:0]                            now_reg;

    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] div_q_reg;
    logic [29:0] rem_reg;
    logic        sat_reg;
    logic [47:0] m_reg;
    logic [31:0] y_reg;
    logic [15:0] frac_reg;
    logic [4:0]  lp_reg;
    logic [20:0] l_reg;
    logic [53:0] e_reg;
    logic [17:0] p_reg;
    logic [16:0] g_reg;

    logic        valid_reg;
    logic        drop_reg;
    logic [31:0] aout_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;

    logic [rqdd_pkg::QFIX_W-1:0] qwide;
    logic [31:0]                 qfix;
    logic [62:0]                 elapsed;
    logic [63:0]                 dq_next;
    logic [29:0]                 rem_next;
    logic [30:0]                 trial;
    logic [16:0]                 lb;
    logic [4:0]                  lead;
    logic [48:0]                 msum;
    logic [63:0]                 bsum;
    logic [63:0]                 fshift;
    logic [32:0]                 sq;

    always_comb
    begin
        qwide = rqdd_pkg::QFIX_W'(qlen_reg) << rqdd_pkg::AVERAGE_FRACTION_BITS;
        if ((rqdd_pkg::QFIX_W > 32) && ((qwide >> 32) != '0))
            qfix = '1;
        else
            qfix = 32'(qwide);
    end

    assign elapsed = (now_reg >= idle_reg) ? (now_reg - idle_reg) : '0;

    // four restoring steps per cycle
    always_comb
    begin
        dq_next  = div_q_reg;
        rem_next = rem_reg;
        for (int i = 0; i < 4; i++)
        begin
            trial = {rem_next, dq_next[63]};
            if (trial >= {1'b0, rqdd_pkg::NS_PER_SECOND})
            begin
                rem_next = 30'(trial - {1'b0, rqdd_pkg::NS_PER_SECOND});
                dq_next  = {dq_next[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[29:0];
                dq_next  = {dq_next[62:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        lb   = 17'(18'd65536 - {2'b0, weight_reg});
        lead = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (lb[i])
                lead = 5'(i);
        end
    end

    assign msum   = {1'b0, m_reg} + {17'b0, div_q_reg[31:0]};
    assign bsum   = acc_reg + prod_reg + 64'd32768;
    assign fshift = prod_reg >> (6'd17 + {1'b0, e_reg[20:16]});
    assign sq     = prod_reg[63:31];

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            rqdd_pkg::OP_BUSY_M1:
            begin
                mul_a = 32'(17'd65536 - {1'b0, weight_reg});
                mul_b = avg_reg;
            end
            rqdd_pkg::OP_BUSY_M2:
            begin
                mul_a = {16'b0, weight_reg};
                mul_b = qfix;
            end
            rqdd_pkg::OP_SECS:
            begin
                mul_a = div_q_reg[31:0];
                mul_b = {16'b0, rate_reg};
            end
            rqdd_pkg::OP_QR:
            begin
                mul_a = {2'b0, rem_reg};
                mul_b = {16'b0, rate_reg};
            end
            rqdd_pkg::OP_LOG_SQ:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            rqdd_pkg::OP_E1:
            begin
                mul_a = m_reg[47:16];
                mul_b = {11'b0, l_reg};
            end
            rqdd_pkg::OP_E2:
            begin
                mul_a = {16'b0, m_reg[15:0]};
                mul_b = {11'b0, l_reg};
            end
            rqdd_pkg::OP_H_MUL:
            begin
                mul_a = {14'b0, p_reg};
                mul_b = {15'b0, g_reg};
            end
            rqdd_pkg::OP_F_MUL:
            begin
                mul_a = avg_reg;
                mul_b = {14'b0, p_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= rqdd_pkg::WEIGHT_RESET;
            thr_reg    <= rqdd_pkg::THRESHOLD_RESET;
            rate_reg   <= rqdd_pkg::RATE_RESET;
            avg_reg    <= '0;
            idle_reg   <= '0;
            valid_reg  <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rqdd_pkg::CFG_WEIGHT:        weight_reg <= cfg_data[15:0];
                    rqdd_pkg::CFG_MAX_THRESHOLD: thr_reg    <= cfg_data;
                    rqdd_pkg::CFG_IDLE_RATE:     rate_reg   <= cfg_data[15:0];
                    default:                     ;
                endcase
            end

            if (cmd.op == rqdd_pkg::OP_RESULT)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;

            unique case (cmd.op)
                rqdd_pkg::OP_MARK:
                    idle_reg <= now_reg;
                rqdd_pkg::OP_BUSY_SUM:
                    avg_reg <= (bsum[63:48] != '0) ? '1 : bsum[47:16];
                rqdd_pkg::OP_ELAPSED:
                    rem_reg <= '0;
                rqdd_pkg::OP_DIV_STEP:
                    rem_reg <= rem_next;
                rqdd_pkg::OP_REM_LOAD:
                    rem_reg <= '0;
                rqdd_pkg::OP_AVG_ZERO:
                    avg_reg <= '0;
                rqdd_pkg::OP_AVG_SHIFT:
                    avg_reg <= avg_reg >> e_reg[20:16];
                rqdd_pkg::OP_F_FIN:
                    avg_reg <= fshift[31:0];
                rqdd_pkg::OP_RESULT:
                begin
                    if (qlen_reg == '0)
                        idle_reg <= now_reg;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= 64'(mul_a) * 64'(mul_b);

        unique case (cmd.op)
            rqdd_pkg::OP_LOAD:
            begin
                act_reg  <= action;
                qlen_reg <= rqdd_pkg::QUEUE_LENGTH_BITS'(queue_length);
                now_reg  <= current_time_ns;
            end
            rqdd_pkg::OP_BUSY_M2:
                acc_reg <= prod_reg;
            rqdd_pkg::OP_ELAPSED:
                div_q_reg <= {1'b0, elapsed};
            rqdd_pkg::OP_DIV_STEP:
                div_q_reg <= dq_next;
            rqdd_pkg::OP_SECS:
                sat_reg <= (div_q_reg[63:32] != '0) && (rate_reg != '0);
            rqdd_pkg::OP_QR:
            begin
                sat_reg <= sat_reg || (prod_reg[63:32] != '0);
                m_reg   <= {prod_reg[31:0], 16'b0};
            end
            rqdd_pkg::OP_REM_LOAD:
                div_q_reg <= {prod_reg[47:0], 16'b0};
            rqdd_pkg::OP_M_SUM:
                m_reg <= (sat_reg || msum[48]) ? rqdd_pkg::M_MAX : msum[47:0];
            rqdd_pkg::OP_LOG_INIT:
            begin
                y_reg    <= 32'({15'b0, lb} << (5'd31 - lead));
                frac_reg <= '0;
                lp_reg   <= lead;
            end
            rqdd_pkg::OP_LOG_NORM:
            begin
                if (sq[32])
                begin
                    frac_reg <= {frac_reg[14:0], 1'b1};
                    y_reg    <= sq[32:1];
                end
                else
                begin
                    frac_reg <= {frac_reg[14:0], 1'b0};
                    y_reg    <= sq[31:0];
                end
            end
            rqdd_pkg::OP_L_FIN:
                l_reg <= {5'd16 - lp_reg, 16'b0} - {5'b0, frac_reg};
            rqdd_pkg::OP_E2:
                acc_reg <= prod_reg;
            rqdd_pkg::OP_E3:
                e_reg <= acc_reg[53:0] + {6'b0, prod_reg[63:16]};
            rqdd_pkg::OP_H_INIT:
            begin
                p_reg <= rqdd_pkg::EXP2_C5;
                g_reg <= 17'(18'd65536 - {2'b0, e_reg[15:0]});
            end
            rqdd_pkg::OP_H_ADD:
                p_reg <= 18'({2'b0, rqdd_pkg::hcoef(cmd.idx)} + prod_reg[34:16]);
            rqdd_pkg::OP_RESULT:
            begin
                drop_reg <= (avg_reg >= thr_reg);
                aout_reg <= avg_reg;
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        sts.action    = act_reg;
        sts.qlen_zero = (qlen_reg == '0);
        sts.e_zero    = (e_reg == '0);
        sts.e_big     = (e_reg[53:21] != '0);
        sts.f_zero    = (e_reg[15:0] == '0);
        sts.out_full  = valid_reg;
    end

    assign out_valid      = valid_reg;
    assign drop           = drop_reg;
    assign average_length = aout_reg;

    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rqdd_pkg::OP_LOG_SQ) |-> y_reg[31])
        else $error("log mantissa not normalised");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < rqdd_pkg::NS_PER_SECOND)
        else $error("divider remainder out of range");

endmodule
`default_nettype wire

/* hdl/rqdd_ctrl.sv */
// ----------------------------------------------------------------------------
// rqdd_ctrl
// Sequencer for the idle mark, the busy update and the idle decay steps.
// ----------------------------------------------------------------------------
`default_nettype none
module rqdd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            out_ready,
    input  wire rqdd_pkg::sts_t  sts,
    output rqdd_pkg::cmd_t       cmd
);

    rqdd_pkg::state_t state_reg, state_next;
    logic [3:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqdd_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = rqdd_pkg::OP_NONE;
        cmd.idx    = cnt_reg[2:0];
        in_ready   = 1'b0;
        unique case (state_reg)
            rqdd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = rqdd_pkg::OP_LOAD;
                    state_next = rqdd_pkg::S_DISPATCH;
                end
            end
            rqdd_pkg::S_DISPATCH:
            begin
                if (sts.action)
                begin
                    cmd.op     = rqdd_pkg::OP_MARK;
                    state_next = rqdd_pkg::S_IDLE;
                end
                else if (!sts.qlen_zero)
                    state_next = rqdd_pkg::S_B1;
                else
                    state_next = rqdd_pkg::S_ELAP;
            end
            rqdd_pkg::S_B1:
            begin
                cmd.op     = rqdd_pkg::OP_BUSY_M1;
                state_next = rqdd_pkg::S_B2;
            end
            rqdd_pkg::S_B2:
            begin
                cmd.op     = rqdd_pkg::OP_BUSY_M2;
                state_next = rqdd_pkg::S_B3;
            end
            rqdd_pkg::S_B3:
            begin
                cmd.op     = rqdd_pkg::OP_BUSY_SUM;
                state_next = rqdd_pkg::S_DONE;
            end
            rqdd_pkg::S_ELAP:
            begin
                cmd.op     = rqdd_pkg::OP_ELAPSED;
                cnt_next   = 4'd15;
                state_next = rqdd_pkg::S_DIV1;
            end
            rqdd_pkg::S_DIV1:
            begin
                cmd.op   = rqdd_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                    state_next = rqdd_pkg::S_SECS;
            end
            rqdd_pkg::S_SECS:
            begin
                cmd.op     = rqdd_pkg::OP_SECS;
                state_next = rqdd_pkg::S_QR;
            end
            rqdd_pkg::S_QR:
            begin
                cmd.op     = rqdd_pkg::OP_QR;
                state_next = rqdd_pkg::S_REML;
            end
            rqdd_pkg::S_REML:
            begin
                cmd.op     = rqdd_pkg::OP_REM_LOAD;
                cnt_next   = 4'd15;
                state_next = rqdd_pkg::S_DIV2;
            end
            rqdd_pkg::S_DIV2:
            begin
                cmd.op   = rqdd_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                    state_next = rqdd_pkg::S_MSUM;
            end
            rqdd_pkg::S_MSUM:
            begin
                cmd.op     = rqdd_pkg::OP_M_SUM;
                state_next = rqdd_pkg::S_LINIT;
            end
            rqdd_pkg::S_LINIT:
            begin
                cmd.op     = rqdd_pkg::OP_LOG_INIT;
                cnt_next   = 4'd15;
                state_next = rqdd_pkg::S_LSQ;
            end
            rqdd_pkg::S_LSQ:
            begin
                cmd.op     = rqdd_pkg::OP_LOG_SQ;
                state_next = rqdd_pkg::S_LNORM;
            end
            rqdd_pkg::S_LNORM:
            begin
                cmd.op   = rqdd_pkg::OP_LOG_NORM;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                    state_next = rqdd_pkg::S_LFIN;
                else
                    state_next = rqdd_pkg::S_LSQ;
            end
            rqdd_pkg::S_LFIN:
            begin
                cmd.op     = rqdd_pkg::OP_L_FIN;
                state_next = rqdd_pkg::S_E1;
            end
            rqdd_pkg::S_E1:
            begin
                cmd.op     = rqdd_pkg::OP_E1;
                state_next = rqdd_pkg::S_E2;
            end
            rqdd_pkg::S_E2:
            begin
                cmd.op     = rqdd_pkg::OP_E2;
                state_next = rqdd_pkg::S_E3;
            end
            rqdd_pkg::S_E3:
            begin
                cmd.op     = rqdd_pkg::OP_E3;
                state_next = rqdd_pkg::S_EDEC;
            end
            rqdd_pkg::S_EDEC:
            begin
                state_next = rqdd_pkg::S_DONE;
                if (sts.e_zero)
                    cmd.op = rqdd_pkg::OP_NONE;
                else if (sts.e_big)
                    cmd.op = rqdd_pkg::OP_AVG_ZERO;
                else if (sts.f_zero)
                    cmd.op = rqdd_pkg::OP_AVG_SHIFT;
                else
                begin
                    cmd.op     = rqdd_pkg::OP_H_INIT;
                    cnt_next   = 4'd4;
                    state_next = rqdd_pkg::S_HMUL;
                end
            end
            rqdd_pkg::S_HMUL:
            begin
                cmd.op     = rqdd_pkg::OP_H_MUL;
                state_next = rqdd_pkg::S_HADD;
            end
            rqdd_pkg::S_HADD:
            begin
                cmd.op   = rqdd_pkg::OP_H_ADD;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                    state_next = rqdd_pkg::S_FMUL;
                else
                    state_next = rqdd_pkg::S_HMUL;
            end
            rqdd_pkg::S_FMUL:
            begin
                cmd.op     = rqdd_pkg::OP_F_MUL;
                state_next = rqdd_pkg::S_FFIN;
            end
            rqdd_pkg::S_FFIN:
            begin
                cmd.op     = rqdd_pkg::OP_F_FIN;
                state_next = rqdd_pkg::S_DONE;
            end
            rqdd_pkg::S_DONE:
            begin
                if (!sts.out_full || out_ready)
                begin
                    cmd.op     = rqdd_pkg::OP_RESULT;
                    state_next = rqdd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rqdd_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == rqdd_pkg::S_DISPATCH))
        else $error("accepted transaction not dispatched");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rqdd_pkg::OP_RESULT) |-> (!sts.out_full || out_ready))
        else $error("result register overwritten");

    a_horner_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rqdd_pkg::S_HADD) |-> (cnt_reg <= 4'd4))
        else $error("Horner index out of range");

endmodule
`default_nettype wire

/* hdl/red_queue_drop_decider_unit.sv */
// ----------------------------------------------------------------------------
// red_queue_drop_decider_unit
// RED dropper average tracker with hard threshold drop decision.
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// check    in   valid/ready      action, queue_length, current_time_ns
// result   out  valid/ready      drop, average_length
// cfg      in   cfg_we           cfg_index, cfg_data
//
// One transaction at a time. Mark: stamps the idle time. Non-empty check:
// busy update through states B1, B2, B3, then the result. Empty check: runs
// the radix-16 divider by 1e9 (two passes) and the shared 32x32 multiplier
// (16 log2 squarings, 5 Horner steps when needed). A waiting result does not
// block the next accept; a finished result stalls until the output register
// frees. Asynchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module red_queue_drop_decider_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rqdd_in_if.sink          check,
    rqdd_out_if.source       result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    rqdd_pkg::cmd_t cmd;
    rqdd_pkg::sts_t sts;
    logic           in_ready;

    assign check.ready = in_ready;

    rqdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (check.valid),
        .in_ready  (in_ready),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rqdd_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (check.action),
        .queue_length    (check.queue_length),
        .current_time_ns (check.current_time_ns),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .drop            (result.drop),
        .average_length  (result.average_length)
    );

endmodule
`default_nettype wire
